### hdl/cct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cct_pkg: shared types and codes for the coalescing change table
// Field widths, item kinds, internal op codes, status codes and the command
// record that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package cct_pkg;

	localparam int TABLE_DEPTH_DEF  = 32;
	localparam int NUM_ENTITIES_DEF = 1024;
	localparam int LEVEL_BITS_DEF   = 4;

	localparam int KIND_W     = 3;
	localparam int ENT_W      = 10;
	localparam int LEVEL_W    = 4;
	localparam int TIME_W     = 31;
	localparam int STATUS_W   = 3;
	localparam int MAXP_W     = 6;
	localparam int INTERVAL_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_DATA_W  = 48;

	// power of two, pointers wrap on their own
	localparam int QUEUE_DEPTH = 2;

	localparam logic [MAXP_W-1:0] MAX_PENDING_RESET = 6'd25;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PENDING     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 1'd1;

	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CHECK = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_START = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd5;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_CHECK = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_START = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_LOAD  = 3'd5;
	localparam logic [2:0] OP_NONE  = 3'd6;

	localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OTHER     = 3'd4;

	typedef struct packed {
		logic [2:0]         op;
		logic [ENT_W-1:0]   ent;
		logic               ent_ok;
		logic [LEVEL_W-1:0] lvl;
		logic [TIME_W-1:0]  now;
	} cmd_t;

endpackage
`default_nettype wire

### hdl/coalescing_change_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_change_table: pending level-change table with flush scheduling
// Coalesces level changes per entity into an ordered table and reports when
// a flush is due, by pending count or by deadline.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result. Items pass a two-entry command
// queue, so the input side keeps taking items while the engine is busy until
// the queue is full, and a result waits in the output register. Check, stop,
// start, clear and load finish in the pop cycle in the engine. An add is
// launched and then searches the table entry by entry. On a cancel the search
// stops at the match and is followed by the close-up of each later entry and a
// closing step. Search and close-up together pass over the table once, and the
// output side can stall an add at its end. The walk over the entry memory,
// which has one read and one write port, moves one entry a cycle. Base levels
// are undefined until loaded.
// ----------------------------------------------------------------------------
module coalescing_change_table #(
	parameter int TABLE_DEPTH  = cct_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_ENTITIES = cct_pkg::NUM_ENTITIES_DEF,
	parameter int LEVEL_BITS   = cct_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// entity_index [9:0], level [13:10], now [44:14], zero fill
	input  wire logic [cct_pkg::IN_DATA_W-1:0]          s_tdata,
	// kind
	input  wire logic [cct_pkg::KIND_W-1:0]             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// status, flush_due, pending_count, zero fill
	output logic [8*((cct_pkg::STATUS_W+1+$clog2(TABLE_DEPTH+1)+7)/8)-1:0] m_tdata,
	input  wire logic                                   wr_en,
	input  wire logic [cct_pkg::CFG_IDX_W-1:0]          wr_index,
	input  wire logic [cct_pkg::CFG_DATA_W-1:0]         wr_data
);
	import cct_pkg::*;

	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_W      = STATUS_W + 1 + CNT_W;
	localparam int OUT_DATA_W = 8 * ((OUT_W + 7) / 8);

	logic [MAXP_W-1:0]     max_pending_q;
	logic [INTERVAL_W-1:0] update_interval_q;

	logic                  q_full;
	logic                  q_push;
	cmd_t                  q_cmd;
	logic                  q_valid;
	logic                  q_pop;
	cmd_t                  q_head;

	logic [STATUS_W-1:0]   out_status;
	logic                  out_flush;
	logic [CNT_W-1:0]      out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pending_q     <= MAX_PENDING_RESET;
			update_interval_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_PENDING:     max_pending_q     <= wr_data[MAXP_W-1:0];
				REG_UPDATE_INTERVAL: update_interval_q <= wr_data[INTERVAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cct_front #(
		.NUM_ENTITIES (NUM_ENTITIES),
		.LEVEL_BITS   (LEVEL_BITS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	cct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	cct_back #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.NUM_ENTITIES (NUM_ENTITIES),
		.LEVEL_BITS   (LEVEL_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.max_pending     (max_pending_q),
		.update_interval (update_interval_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_status      (out_status),
		.out_flush       (out_flush),
		.out_count       (out_count)
	);

	assign m_tdata = OUT_DATA_W'({out_count, out_flush, out_status});

endmodule
`default_nettype wire

### hdl/cct_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cct_front: input decode
// Unpacks the input stream, maps the item kind to an op code, masks the level
// and range-checks the entity, then pushes the command into the queue.
// ----------------------------------------------------------------------------
module cct_front #(
	parameter int NUM_ENTITIES = cct_pkg::NUM_ENTITIES_DEF,
	parameter int LEVEL_BITS   = cct_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [cct_pkg::IN_DATA_W-1:0]  s_tdata,  // entity_index, level, now
	input  wire logic [cct_pkg::KIND_W-1:0]     s_tuser,  // kind
	input  wire logic                           q_full,
	output logic                                q_push,
	output cct_pkg::cmd_t                       q_cmd
);
	import cct_pkg::*;

	localparam logic [LEVEL_W-1:0] LVL_MASK = LEVEL_W'((1 << LEVEL_BITS) - 1);

	logic [ENT_W-1:0]   ent;
	logic [LEVEL_W-1:0] lvl;
	logic [TIME_W-1:0]  now;

	assign ent = s_tdata[ENT_W-1:0];
	assign lvl = s_tdata[ENT_W+LEVEL_W-1:ENT_W];
	assign now = s_tdata[ENT_W+LEVEL_W+TIME_W-1:ENT_W+LEVEL_W];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_cmd.ent    = ent;
		q_cmd.ent_ok = (32'(ent) < 32'(NUM_ENTITIES));
		q_cmd.lvl    = lvl & LVL_MASK;
		q_cmd.now    = now;
		unique case (s_tuser)
			KIND_ADD:   q_cmd.op = OP_ADD;
			KIND_CHECK: q_cmd.op = OP_CHECK;
			KIND_STOP:  q_cmd.op = OP_STOP;
			KIND_START: q_cmd.op = OP_START;
			KIND_CLEAR: q_cmd.op = OP_CLEAR;
			KIND_LOAD:  q_cmd.op = OP_LOAD;
			default:    q_cmd.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

### hdl/cct_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cct_queue: command queue
// Short register FIFO between the decode front end and the table back end.
// ----------------------------------------------------------------------------
module cct_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cct_pkg::cmd_t  push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                valid,
	output cct_pkg::cmd_t       head
);
	import cct_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full  = (fill_q == FILL_MAX);
	assign valid = (fill_q != '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hdl/cct_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cct_back: table engine
// Walks the pending-change table in a memory with one read and one write port,
// one entry a cycle; appends, updates, cancels with close-up or drops when full,
// handles check, stop, start, clear and base-level load, and holds the result register.
// ----------------------------------------------------------------------------
module cct_back #(
	parameter int TABLE_DEPTH  = cct_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_ENTITIES = cct_pkg::NUM_ENTITIES_DEF,
	parameter int LEVEL_BITS   = cct_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             q_valid,
	input  wire cct_pkg::cmd_t                    q_head,
	output logic                                  q_pop,
	input  wire logic [cct_pkg::MAXP_W-1:0]       max_pending,
	input  wire logic [cct_pkg::INTERVAL_W-1:0]   update_interval,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [cct_pkg::STATUS_W-1:0]          out_status,
	output logic                                  out_flush,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]      out_count
);
	import cct_pkg::*;

	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int BASE_AW = $clog2(NUM_ENTITIES);
	localparam int LVL_W   = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;
	localparam int CMP_W   = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;

	typedef struct packed {
		logic [ENT_W-1:0] ent;
		logic [LVL_W-1:0] old_lvl;
		logic [LVL_W-1:0] new_lvl;
	} entry_t;

	entry_t               entry_mem [TABLE_DEPTH];
	logic [LVL_W-1:0]     base_mem [NUM_ENTITIES];

	logic [1:0]           state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     i_q, i_d;
	logic [CNT_W-1:0]     j_q, j_d;
	logic                 active_q, active_d;
	logic [TIME_W-1:0]    deadline_q, deadline_d;
	cmd_t                 cmd_q;

	entry_t               rd_entry_q;
	entry_t               wr_entry;
	logic                 entry_we;
	logic [CNT_W-1:0]     rd_idx;
	logic [CNT_W-1:0]     wr_idx;
	logic [LVL_W-1:0]     base_rd_q;
	logic [BASE_AW-1:0]   base_addr;
	logic                 base_we;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic                 out_flush_q;
	logic [CNT_W-1:0]     out_count_q;

	logic                 out_free;
	logic                 commit;
	logic [STATUS_W-1:0]  status_d;
	logic                 flush_d;
	logic [LVL_W-1:0]     cmd_lvl;
	logic                 in_table;
	logic                 hit;
	logic                 cancel;
	logic                 more;
	logic                 due;
	logic [TIME_W-1:0]    rearm;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_flush  = out_flush_q;
	assign out_count  = out_count_q;

	assign out_free = !out_valid_q || out_ready;
	assign cmd_lvl  = cmd_q.lvl[LVL_W-1:0];
	assign in_table = (i_q < count_q);
	assign hit      = in_table && (rd_entry_q.ent == cmd_q.ent);
	assign cancel   = hit && (rd_entry_q.old_lvl == cmd_lvl);
	assign more     = ((j_q + CNT_ONE) < count_q);
	assign rearm    = q_head.now + TIME_W'(update_interval);
	assign due      = active_q && (count_q != '0) &&
		((CMP_W'(count_q) >= CMP_W'(max_pending)) || (q_head.now >= deadline_q));

	// an add starts its walk at once, other items finish in the pop cycle
	assign q_pop = (state_q == S_IDLE) && q_valid && ((q_head.op == OP_ADD) || out_free);

	assign base_addr = (state_q == S_IDLE) ? BASE_AW'(q_head.ent) : BASE_AW'(cmd_q.ent);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		i_d        = i_q;
		j_d        = j_q;
		active_d   = active_q;
		deadline_d = deadline_q;
		rd_idx     = '0;
		entry_we   = 1'b0;
		wr_idx     = i_q;
		wr_entry   = rd_entry_q;
		base_we    = 1'b0;
		commit     = 1'b0;
		status_d   = ST_OTHER;
		flush_d    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					commit = (q_head.op != OP_ADD);
					unique case (q_head.op)
						OP_ADD: begin
							state_d = S_SEARCH;
							i_d     = '0;
						end
						OP_CHECK: begin
							if (due) begin
								flush_d    = 1'b1;
								deadline_d = rearm;
							end
						end
						OP_STOP: begin
							active_d   = 1'b0;
							deadline_d = q_head.now;
							count_d    = '0;
						end
						OP_START: begin
							active_d   = 1'b1;
							deadline_d = rearm;
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						OP_LOAD: begin
							base_we = q_head.ent_ok;
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				rd_idx = i_q;
				if (cancel) begin
					state_d = S_SHIFT;
					j_d     = i_q;
					rd_idx  = i_q + CNT_ONE;
				end else if (hit) begin
					if (out_free) begin
						entry_we         = 1'b1;
						wr_idx           = i_q;
						wr_entry.new_lvl = cmd_lvl;
						commit           = 1'b1;
						status_d         = ST_UPDATED;
						state_d          = S_IDLE;
					end
				end else if (in_table) begin
					i_d    = i_q + CNT_ONE;
					rd_idx = i_q + CNT_ONE;
				end else if (out_free) begin
					commit  = 1'b1;
					state_d = S_IDLE;
					if (count_q == DEPTH_C) begin
						status_d = ST_DROPPED;
					end else begin
						status_d         = ST_APPENDED;
						entry_we         = 1'b1;
						wr_idx           = count_q;
						wr_entry.ent     = cmd_q.ent;
						wr_entry.old_lvl = cmd_q.ent_ok ? base_rd_q : '0;
						wr_entry.new_lvl = cmd_lvl;
						count_d          = count_q + CNT_ONE;
					end
				end
			end
			S_SHIFT: begin
				// rd_entry_q holds entry j+1, move it down to j
				if (more) begin
					entry_we = 1'b1;
					wr_idx   = j_q;
					wr_entry = rd_entry_q;
					j_d      = j_q + CNT_ONE;
					rd_idx   = j_q + CNT_TWO;
				end else begin
					rd_idx = j_q;
					if (out_free) begin
						commit   = 1'b1;
						status_d = ST_CANCELLED;
						count_d  = count_q - CNT_ONE;
						state_d  = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (entry_we) begin
			entry_mem[wr_idx[IDX_W-1:0]] <= wr_entry;
		end
		rd_entry_q <= entry_mem[rd_idx[IDX_W-1:0]];
		if (base_we) begin
			base_mem[BASE_AW'(q_head.ent)] <= q_head.lvl[LVL_W-1:0];
		end
		base_rd_q <= base_mem[base_addr];
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (commit) begin
			out_status_q <= status_d;
			out_flush_q  <= flush_d;
			out_count_q  <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			active_q    <= 1'b1;
			deadline_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			i_q        <= i_d;
			j_q        <= j_d;
			active_q   <= active_d;
			deadline_q <= deadline_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("pending count above table depth");

	a_flush_other: assert property (@(posedge clk) disable iff (!arst_n)
		commit && flush_d |-> status_d == ST_OTHER)
		else $error("flush reported on a non-check result");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> j_q < count_q)
		else $error("close-up index past the pending entries");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		commit && status_d == ST_APPENDED |=> count_q == $past(count_q) + CNT_ONE)
		else $error("append did not grow the table");

	a_no_commit_full: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> out_free)
		else $error("result written over one not yet taken");

endmodule
`default_nettype wire
